// ===== rtl/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// Shared widths, register codes, reset values and tables for the arrive
// steering step.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int POS_W    = 24;
    localparam int VEL_W    = 19;
    localparam int SPD_W    = 18;
    localparam int MOVE_W   = 15;
    localparam int TURN_W   = 16;
    localparam int DT_W     = 16;
    localparam int HD_W     = 16;
    localparam int MAXS_W   = 18;
    localparam int RAD_W    = 23;
    localparam int DIFF_W   = 25;
    localparam int DIST_W   = 25;
    localparam int NUM_W    = 51;
    localparam int QUO_W    = 26;
    localparam int MUL_W    = 26;
    localparam int CORD_W   = 34;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 23;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 176;

    localparam logic [IDX_W-1:0] REG_MAX_SPEED     = 2'd0;
    localparam logic [IDX_W-1:0] REG_SLOW_RADIUS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_ARRIVE_RADIUS = 2'd2;

    localparam logic [MAXS_W-1:0] MAX_SPEED_RST     = 18'd51200;
    localparam logic [RAD_W-1:0]  SLOW_RADIUS_RST   = 23'd64000;
    localparam logic [RAD_W-1:0]  ARRIVE_RADIUS_RST = 23'd8960;

    localparam logic [MOVE_W-1:0] ONE_Q14 = 15'd16384;

    localparam int CORDIC_ITER_DEFAULT = 16;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [29:0] ATAN_Q30 [24] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DIST_W-1:0] den;
    } div_req_t;

endpackage

// ===== rtl/ast_div.sv =====
// ----------------------------------------------------------------------------
// ast_div
// Restoring divider, one quotient bit per cycle. Quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module ast_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ast_pkg::div_req_t             req,
    output logic                          done,
    output logic [ast_pkg::QUO_W-1:0]     quo
);

    localparam int QW = ast_pkg::QUO_W;
    localparam int DW = ast_pkg::DIST_W;
    localparam int NW = ast_pkg::NUM_W;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] sh_reg;
    logic [QW-1:0] quo_reg;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
                rem_reg  <= req.num[NW-1:QW];
                sh_reg   <= req.num[QW-1:0];
                den_reg  <= req.den;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                sh_reg  <= {sh_reg[QW-2:0], 1'b0};
                quo_reg <= {quo_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/arrive_steering_step.sv =====
// ----------------------------------------------------------------------------
// arrive_steering_step
// Moves a point toward a target each tick and reports motion and turn.
// ----------------------------------------------------------------------------
// Input beats on s_* carry target point, time step and heading; each gives
// exactly one result beat on m_*, with the arrival flag in m_tuser.
// Registers max_speed, slow_radius and arrive_radius are written on cfg_*
// (always ready); the user must write them only while the block is idle,
// which the block itself does not enforce. One beat is worked at a time:
// s_tready is high only in the idle state. The time to a result is set by
// the shared divider (up to eight divisions per beat), the 26-step square
// root and the CORDIC loop. Inside the arrive radius no division runs; a
// step that snaps to the radius edge divides for the two offsets only; a
// normal move adds direction, velocity and move-level divisions and CORDIC;
// a distance inside the slow radius adds the speed factor division.
// The result sits in an output register; the next beat is accepted while
// it waits. If m_tready stays low, the next result holds until it drains.
// Reset restores the register defaults and clears position and velocity.
// ----------------------------------------------------------------------------
module arrive_steering_step #(
    parameter int CORDIC_ITERATIONS = ast_pkg::CORDIC_ITER_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // target_x, target_y, time_step, heading
    input  logic [ast_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x, pos_y, vel_x, vel_y, prev_vel_x, prev_vel_y, speed_now,
    // move_level, turn_level, zero pad
    output logic [ast_pkg::M_DATA_W-1:0]    m_tdata,
    // arrived
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ast_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ast_pkg::CFG_W-1:0]       cfg_data
);

    localparam int IT_W = $clog2(CORDIC_ITERATIONS);
    localparam int CW   = ast_pkg::CORD_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQADD, S_SQRT, S_CHK, S_FWAIT, S_SPD, S_SPD2,
        S_STP, S_STP2, S_JMUL, S_JDIV, S_JWAIT, S_MDIV, S_MWAIT, S_CINIT,
        S_CORD, S_CFIN, S_T1, S_T2, S_T3, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        JOB_DIRX, JOB_DIRY, JOB_VX, JOB_VY, JOB_OFFX, JOB_OFFY
    } job_t;

    state_t state_reg;
    job_t   job_reg;

    logic [ast_pkg::MAXS_W-1:0] max_speed_reg;
    logic [ast_pkg::RAD_W-1:0]  slow_radius_reg;
    logic [ast_pkg::RAD_W-1:0]  arrive_radius_reg;

    logic signed [ast_pkg::POS_W-1:0] pos_x_reg, pos_y_reg;
    logic signed [ast_pkg::VEL_W-1:0] last_vx_reg, last_vy_reg;

    logic signed [ast_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic [ast_pkg::DT_W-1:0]          dt_reg;
    logic [ast_pkg::HD_W-1:0]          hd_reg;

    logic [ast_pkg::NUM_W-1:0]  n_reg, res_reg, bit_reg;
    logic [ast_pkg::DIST_W-1:0] dist_reg, margin_reg;
    logic [ast_pkg::MOVE_W-1:0] factor_reg;
    logic [ast_pkg::SPD_W-1:0]  speed_reg, step_reg;
    logic                       edge_reg, arrived_reg;

    logic signed [ast_pkg::TURN_W-1:0] dirx_reg, diry_reg, turn_reg;
    logic signed [ast_pkg::VEL_W-1:0]  vx_reg, vy_reg;
    logic signed [ast_pkg::QUO_W-1:0]  offx_reg, offy_reg;
    logic [ast_pkg::MOVE_W-1:0]        move_reg;

    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic                 flip_reg;
    logic [IT_W-1:0]      iter_reg;
    logic signed [17:0]   c_reg, s_reg;
    logic signed [34:0]   t1_reg;

    logic signed [ast_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*ast_pkg::MUL_W-1:0] prod_reg;

    logic                              m_tvalid_reg;
    logic [ast_pkg::M_DATA_W-1:0]      m_tdata_reg;
    logic                              m_tuser_reg;

    ast_pkg::div_req_t           div_req;
    logic                        div_done;
    logic [ast_pkg::QUO_W-1:0]   div_quo;

    ast_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    function automatic logic signed [ast_pkg::MUL_W-1:0] MUL_W_SX(
        input logic signed [ast_pkg::DIFF_W-1:0] v);
        return {v[ast_pkg::DIFF_W-1], v};
    endfunction

    // magnitudes and job operands
    logic [ast_pkg::DIFF_W-1:0] mag_x, mag_y, mag_j;
    logic                       job_y, neg_j;
    logic [ast_pkg::DIST_W-1:0] job_num;
    logic [ast_pkg::DIST_W-1:0] dist_now;
    logic [ast_pkg::SPD_W-1:0]  step_now;

    assign mag_x = dx_reg[ast_pkg::DIFF_W-1] ? (~dx_reg + 1'b1) : dx_reg;
    assign mag_y = dy_reg[ast_pkg::DIFF_W-1] ? (~dy_reg + 1'b1) : dy_reg;
    assign job_y = (job_reg == JOB_DIRY) || (job_reg == JOB_VY) || (job_reg == JOB_OFFY);
    assign mag_j = job_y ? mag_y : mag_x;
    assign neg_j = job_y ? dy_reg[ast_pkg::DIFF_W-1] : dx_reg[ast_pkg::DIFF_W-1];
    assign dist_now = res_reg[ast_pkg::DIST_W-1:0];
    assign step_now = prod_reg[33:16];

    always_comb begin
        unique case (job_reg)
            JOB_DIRX, JOB_DIRY: job_num = ast_pkg::DIST_W'(ast_pkg::ONE_Q14);
            JOB_VX, JOB_VY:     job_num = ast_pkg::DIST_W'(speed_reg);
            default:            job_num = edge_reg ? margin_reg
                                                   : ast_pkg::DIST_W'(step_reg);
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_SQX:   begin mul_a = MUL_W_SX(dx_reg); mul_b = MUL_W_SX(dx_reg); end
            S_SQY:   begin mul_a = MUL_W_SX(dy_reg); mul_b = MUL_W_SX(dy_reg); end
            S_SPD:   begin
                mul_a = ast_pkg::MUL_W'(max_speed_reg);
                mul_b = ast_pkg::MUL_W'(factor_reg);
            end
            S_STP:   begin
                mul_a = ast_pkg::MUL_W'(speed_reg);
                mul_b = ast_pkg::MUL_W'(dt_reg);
            end
            S_JMUL:  begin
                mul_a = ast_pkg::MUL_W'(mag_j);
                mul_b = ast_pkg::MUL_W'(job_num);
            end
            S_T1:    begin
                mul_a = ast_pkg::MUL_W'(c_reg);
                mul_b = ast_pkg::MUL_W'(diry_reg);
            end
            S_T2:    begin
                mul_a = ast_pkg::MUL_W'(s_reg);
                mul_b = ast_pkg::MUL_W'(dirx_reg);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            S_CHK: begin
                div_req.start = (dist_now > ast_pkg::DIST_W'(arrive_radius_reg))
                             && (slow_radius_reg != '0)
                             && (dist_now < ast_pkg::DIST_W'(slow_radius_reg));
                div_req.num   = ast_pkg::NUM_W'({dist_now, 14'b0});
                div_req.den   = ast_pkg::DIST_W'(slow_radius_reg);
            end
            S_JDIV: begin
                div_req.start = 1'b1;
                div_req.num   = prod_reg[ast_pkg::NUM_W-1:0]
                              + ast_pkg::NUM_W'(dist_reg >> 1);
                div_req.den   = dist_reg;
            end
            S_MDIV: begin
                div_req.start = max_speed_reg != '0;
                div_req.num   = ast_pkg::NUM_W'({speed_reg, 14'b0});
                div_req.den   = ast_pkg::DIST_W'(max_speed_reg);
            end
            default: ;
        endcase
    end

    // square root step
    logic [ast_pkg::NUM_W-1:0] rb;
    assign rb = res_reg + bit_reg;

    // CORDIC step
    logic signed [CW-1:0] xs, ys;
    logic signed [CW-1:0] atan_i;
    assign xs     = cx_reg >>> iter_reg;
    assign ys     = cy_reg >>> iter_reg;
    assign atan_i = CW'(ast_pkg::ATAN_Q30[5'(iter_reg)]);

    logic signed [CW-1:0] xf, yf;
    assign xf = (flip_reg ? -cx_reg : cx_reg) + CW'(32768);
    assign yf = (flip_reg ? -cy_reg : cy_reg) + CW'(32768);

    logic signed [35:0] tsum;
    logic signed [21:0] tsh;
    assign tsum = 36'(t1_reg) - 36'($signed(prod_reg[34:0])) + 36'sd8192;
    assign tsh  = tsum[35:14];

    // signed job quotient
    logic signed [ast_pkg::QUO_W:0] qs;
    assign qs = neg_j ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    // new position
    logic signed [ast_pkg::POS_W+2:0] nx, ny;
    logic signed [ast_pkg::POS_W-1:0] sx, sy;
    assign nx = 27'(pos_x_reg) + 27'(offx_reg);
    assign ny = 27'(pos_y_reg) + 27'(offy_reg);
    assign sx = (nx > 27'sd8388607) ? 24'sh7FFFFF :
                (nx < -27'sd8388608) ? 24'sh800000 : nx[ast_pkg::POS_W-1:0];
    assign sy = (ny > 27'sd8388607) ? 24'sh7FFFFF :
                (ny < -27'sd8388608) ? 24'sh800000 : ny[ast_pkg::POS_W-1:0];

    logic [ast_pkg::SPD_W-1:0] speed_out;
    assign speed_out = arrived_reg ? '0 : speed_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            job_reg           <= JOB_DIRX;
            max_speed_reg     <= ast_pkg::MAX_SPEED_RST;
            slow_radius_reg   <= ast_pkg::SLOW_RADIUS_RST;
            arrive_radius_reg <= ast_pkg::ARRIVE_RADIUS_RST;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            last_vx_reg       <= '0;
            last_vy_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    ast_pkg::REG_MAX_SPEED:     max_speed_reg <= cfg_data[ast_pkg::MAXS_W-1:0];
                    ast_pkg::REG_SLOW_RADIUS:   slow_radius_reg <= cfg_data;
                    ast_pkg::REG_ARRIVE_RADIUS: arrive_radius_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        dx_reg <= {s_tdata[23], s_tdata[23:0]} - {pos_x_reg[23], pos_x_reg};
                        dy_reg <= {s_tdata[47], s_tdata[47:24]} - {pos_y_reg[23], pos_y_reg};
                        dt_reg <= s_tdata[63:48];
                        hd_reg <= s_tdata[79:64];
                        state_reg <= S_SQX;
                    end
                end
                S_SQX: state_reg <= S_SQY;
                S_SQY: begin
                    n_reg     <= prod_reg[ast_pkg::NUM_W-1:0];
                    state_reg <= S_SQADD;
                end
                S_SQADD: begin
                    n_reg     <= n_reg + prod_reg[ast_pkg::NUM_W-1:0];
                    res_reg   <= '0;
                    bit_reg   <= ast_pkg::NUM_W'(1) << (ast_pkg::NUM_W - 1);
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (n_reg >= rb) begin
                        n_reg   <= n_reg - rb;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    dist_reg    <= dist_now;
                    margin_reg  <= dist_now - ast_pkg::DIST_W'(arrive_radius_reg);
                    arrived_reg <= 1'b1;
                    vx_reg      <= '0;
                    vy_reg      <= '0;
                    offx_reg    <= '0;
                    offy_reg    <= '0;
                    move_reg    <= '0;
                    turn_reg    <= '0;
                    if (dist_now <= ast_pkg::DIST_W'(arrive_radius_reg)) begin
                        state_reg <= S_OUT;
                    end else if (div_req.start) begin
                        state_reg <= S_FWAIT;
                    end else begin
                        factor_reg <= ast_pkg::ONE_Q14;
                        state_reg  <= S_SPD;
                    end
                end
                S_FWAIT: begin
                    if (div_done) begin
                        factor_reg <= div_quo[ast_pkg::MOVE_W-1:0];
                        state_reg  <= S_SPD;
                    end
                end
                S_SPD: state_reg <= S_SPD2;
                S_SPD2: begin
                    speed_reg <= prod_reg[31:14];
                    state_reg <= S_STP;
                end
                S_STP: state_reg <= S_STP2;
                S_STP2: begin
                    step_reg <= step_now;
                    if (ast_pkg::DIST_W'(step_now) >= margin_reg) begin
                        edge_reg <= 1'b1;
                        job_reg  <= JOB_OFFX;
                    end else begin
                        edge_reg    <= 1'b0;
                        arrived_reg <= 1'b0;
                        job_reg     <= JOB_DIRX;
                    end
                    state_reg <= S_JMUL;
                end
                S_JMUL: state_reg <= S_JDIV;
                S_JDIV: state_reg <= S_JWAIT;
                S_JWAIT: begin
                    if (div_done) begin
                        unique case (job_reg)
                            JOB_DIRX: dirx_reg <= qs[ast_pkg::TURN_W-1:0];
                            JOB_DIRY: diry_reg <= qs[ast_pkg::TURN_W-1:0];
                            JOB_VX:   vx_reg   <= qs[ast_pkg::VEL_W-1:0];
                            JOB_VY:   vy_reg   <= qs[ast_pkg::VEL_W-1:0];
                            JOB_OFFX: offx_reg <= qs[ast_pkg::QUO_W-1:0];
                            default:  offy_reg <= qs[ast_pkg::QUO_W-1:0];
                        endcase
                        if (job_reg == JOB_OFFY) begin
                            state_reg <= edge_reg ? S_OUT : S_MDIV;
                        end else begin
                            job_reg   <= job_t'(job_reg + 3'd1);
                            state_reg <= S_JMUL;
                        end
                    end
                end
                S_MDIV: begin
                    state_reg <= div_req.start ? S_MWAIT : S_CINIT;
                end
                S_MWAIT: begin
                    if (div_done) begin
                        move_reg  <= (div_quo > ast_pkg::QUO_W'(ast_pkg::ONE_Q14))
                                   ? ast_pkg::ONE_Q14 : div_quo[ast_pkg::MOVE_W-1:0];
                        state_reg <= S_CINIT;
                    end
                end
                S_CINIT: begin
                    cx_reg    <= ast_pkg::CORDIC_GAIN_Q30;
                    cy_reg    <= '0;
                    flip_reg  <= hd_reg[15] ^ hd_reg[14];
                    cz_reg    <= CW'($signed({hd_reg[15] ^ (hd_reg[15] ^ hd_reg[14]),
                                              hd_reg[14:0], 16'b0}));
                    iter_reg  <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD: begin
                    if (!cz_reg[CW-1]) begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_i;
                    end else begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_i;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == IT_W'(CORDIC_ITERATIONS - 1)) begin
                        state_reg <= S_CFIN;
                    end
                end
                S_CFIN: begin
                    c_reg     <= xf[CW-1:16];
                    s_reg     <= yf[CW-1:16];
                    state_reg <= S_T1;
                end
                S_T1: state_reg <= S_T2;
                S_T2: begin
                    t1_reg    <= prod_reg[34:0];
                    state_reg <= S_T3;
                end
                S_T3: begin
                    if (tsh > 22'sd16384) begin
                        turn_reg <= 16'sd16384;
                    end else if (tsh < -22'sd16384) begin
                        turn_reg <= -16'sd16384;
                    end else begin
                        turn_reg <= tsh[ast_pkg::TURN_W-1:0];
                    end
                    state_reg <= S_OUT;
                end
                default: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= arrived_reg;
                        m_tdata_reg  <= {3'b0, turn_reg, move_reg, speed_out,
                                         last_vy_reg, last_vx_reg, vy_reg, vx_reg, sy, sx};
                        pos_x_reg    <= sx;
                        pos_y_reg    <= sy;
                        last_vx_reg  <= vx_reg;
                        last_vy_reg  <= vy_reg;
                        state_reg    <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule
